/* hw/rtl/qrts_pkg.sv */
package qrts_pkg;

  localparam int CRD_W  = 7;
  localparam int STEP_W = 5;

  localparam logic [1:0] OP_RESTART  = 2'd0;
  localparam logic [1:0] OP_FETCH    = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;

  localparam logic [1:0] K_QRS  = 2'd0;
  localparam logic [1:0] K_SAPP = 2'd1;
  localparam logic [1:0] K_QRD  = 2'd2;
  localparam logic [1:0] K_DAPP = 2'd3;
  localparam logic [2:0] KX_NONE = 3'd4;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_DOING = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [1:0] FS_GIVEN   = 2'd0;
  localparam logic [1:0] FS_PENDING = 2'd1;
  localparam logic [1:0] FS_ALLDONE = 2'd2;

  localparam logic [0:0] CFG_ROWS = 1'b0;
  localparam logic [0:0] CFG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [3:0] step;
  } tile_t;

  typedef struct packed {
    logic [CRD_W-1:0] rows;
    logic [CRD_W-1:0] cols;
  } grid_t;

  typedef struct packed {
    logic [CRD_W-1:0]  row;
    logic [CRD_W-1:0]  col;
    logic [1:0]        kind;
    logic [STEP_W-1:0] step;
  } target_t;

  function automatic logic [2:0] kind_at(input logic [CRD_W-1:0] r,
                                         input logic [CRD_W-1:0] c,
                                         input logic [STEP_W-1:0] s);
    logic [CRD_W-1:0] sx;
    sx = {{(CRD_W-STEP_W){1'b0}}, s};
    kind_at = KX_NONE;
    if (r == sx) begin
      if (c == sx) kind_at = {1'b0, K_QRS};
      else if (c > sx) kind_at = {1'b0, K_SAPP};
    end else if (r > sx) begin
      if (c == sx) kind_at = {1'b0, K_QRD};
      else if (c > sx) kind_at = {1'b0, K_DAPP};
    end
  endfunction

  function automatic logic passed(input tile_t e, input logic [STEP_W-1:0] t);
    logic [STEP_W-1:0] st;
    st = {1'b0, e.step};
    passed = (st > t) || ((st == t) && (e.status == ST_DONE));
  endfunction

endpackage

/* hw/rtl/qrts_tile_mem.sv */
module qrts_tile_mem #(
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  qrts_pkg::tile_t   wdata,
  input  logic [AW-1:0]     raddr,
  output qrts_pkg::tile_t   rdata
);

  qrts_pkg::tile_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/qrts_cfg.sv */
module qrts_cfg #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  output qrts_pkg::grid_t     grid
);

  localparam logic [qrts_pkg::CRD_W-1:0] MR = qrts_pkg::CRD_W'(MAX_ROWS);
  localparam logic [qrts_pkg::CRD_W-1:0] MC = qrts_pkg::CRD_W'(MAX_COLS);

  logic [4:0] rows_r, cols_r;
  logic [qrts_pkg::CRD_W-1:0] rx, cx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 5'd16;
      cols_r <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == {1'b0, qrts_pkg::CFG_ROWS}) rows_r <= cfg_data;
      if (cfg_index == {1'b0, qrts_pkg::CFG_COLS}) cols_r <= cfg_data;
    end
  end

  // saturate to 1..max
  always_comb begin
    rx = {{(qrts_pkg::CRD_W-5){1'b0}}, rows_r};
    cx = {{(qrts_pkg::CRD_W-5){1'b0}}, cols_r};
    grid.rows = (rx == '0) ? qrts_pkg::CRD_W'(1) : ((rx > MR) ? MR : rx);
    grid.cols = (cx == '0) ? qrts_pkg::CRD_W'(1) : ((cx > MC) ? MC : cx);
  end

endmodule

/* hw/rtl/tiled_qr_task_scheduler.sv */
// channel  | ports                                          | beat taken when
// ---------+------------------------------------------------+--------------------------
// command  | start, busy, in_opcode, in_tile_row/col        | start && !busy
// result   | out_valid, out_fetch_status, out_task_*        | out_valid (one cycle)
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | cfg_valid && cfg_ready
//
// one command at a time, all tile state in one tile memory (registered read)
// restart and reset sweep every entry of the memory, MAX_ROWS*MAX_COLS (pow2-rounded)
// fetch scans one tile per cycle, from the last tile back, and stops at a ready tile
// complete: S_HRD reads and S_HEV marks the tile done, then each successor passes
// through S_GEN and one S_CRD/S_CEV pair per dependency read
// reset is synchronous; the receiver cannot stall results
module tiled_qr_task_scheduler #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_tile_row,
  input  logic [3:0] in_tile_col,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  output logic       out_valid,
  output logic [1:0] out_fetch_status,
  output logic [3:0] out_task_row,
  output logic [3:0] out_task_col,
  output logic [1:0] out_task_kind,
  output logic [3:0] out_task_step
);

  localparam int CW_ = qrts_pkg::CRD_W;
  localparam int SW_ = qrts_pkg::STEP_W;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_HRD   = 8'b0000_1000,
    S_HEV   = 8'b0001_0000,
    S_GEN   = 8'b0010_0000,
    S_CRD   = 8'b0100_0000,
    S_CEV   = 8'b1000_0000
  } state_t;

  typedef enum logic [3:0] {
    G_LOOP = 4'b0001,
    G_SELF = 4'b0010,
    G_TAIL = 4'b0100,
    G_END  = 4'b1000
  } gen_t;

  function automatic logic [AW-1:0] mk_addr(input logic [CW_-1:0] r,
                                            input logic [CW_-1:0] c);
    mk_addr = {r[RW-1:0], c[CW-1:0]};
  endfunction

  qrts_pkg::grid_t grid;
  qrts_pkg::tile_t rd, wd;
  logic            we;
  logic [AW-1:0]   wa, ra;

  state_t state_r, state_nxt;
  gen_t   gstg_r, gstg_nxt;
  logic              set_r, set_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              clr_op_r, clr_op_nxt;
  logic [CW_-1:0]    p_r, p_nxt, q_r, q_nxt, j_r, j_nxt;
  logic [SW_-1:0]    k_r, k_nxt;
  logic [2:0]        hk_r, hk_nxt;
  qrts_pkg::target_t tgt_r, tgt_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [CW_-1:0]    sr_r, sr_nxt, sc_r, sc_nxt, vr_r, vr_nxt, vc_r, vc_nxt;
  logic              pend_r, pend_nxt, idone_r, idone_nxt, doing_r, doing_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        ofs_r, ofs_nxt, okind_r, okind_nxt;
  logic [3:0]        orow_r, orow_nxt, ocol_r, ocol_nxt, ostep_r, ostep_nxt;

  // dependency read for the current target and phase
  logic              d_final, d_chk, d_last;
  logic [CW_-1:0]    d_r, d_c;
  logic [SW_-1:0]    d_t;
  logic [1:0]        d_kind;
  logic [CW_-1:0]    sx;
  logic              d_ok;
  logic [2:0]        nk;
  logic              accept;

  qrts_cfg #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .grid(grid)
  );

  qrts_tile_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign out_valid        = ov_r;
  assign out_fetch_status = ofs_r;
  assign out_task_row     = orow_r;
  assign out_task_col     = ocol_r;
  assign out_task_kind    = okind_r;
  assign out_task_step    = ostep_r;

  always_comb begin
    sx      = {{(CW_-SW_){1'b0}}, tgt_r.step};
    d_final = 1'b0;
    d_chk   = 1'b0;
    d_last  = 1'b0;
    d_r     = tgt_r.row;
    d_c     = tgt_r.col;
    d_t     = tgt_r.step - SW_'(1);
    d_kind  = qrts_pkg::K_DAPP;
    case (tgt_r.kind)
      qrts_pkg::K_SAPP: begin
        if (ph_r == 2'd0) begin
          if (tgt_r.row == '0) d_final = 1'b1;
          d_r = sx; d_c = sx; d_t = tgt_r.step;
          d_kind = qrts_pkg::K_QRS; d_chk = 1'b1;
        end else begin
          d_chk = 1'b1; d_last = 1'b1;
        end
      end
      qrts_pkg::K_QRD: begin
        if (ph_r == 2'd0) begin
          d_r = tgt_r.row - CW_'(1); d_t = tgt_r.step;
        end else begin
          if (tgt_r.step == '0) d_final = 1'b1;
          d_chk = 1'b1; d_last = 1'b1;
        end
      end
      qrts_pkg::K_DAPP: begin
        if (ph_r == 2'd0) begin
          d_c = sx; d_t = tgt_r.step;
          d_kind = qrts_pkg::K_QRD; d_chk = 1'b1;
        end else if (ph_r == 2'd1) begin
          d_r = tgt_r.row - CW_'(1); d_t = tgt_r.step;
        end else begin
          if (tgt_r.step == '0) d_final = 1'b1;
          d_chk = 1'b1; d_last = 1'b1;
        end
      end
      default: d_final = 1'b1;
    endcase
    d_ok = qrts_pkg::passed(rd, d_t) && (!d_chk || (rd.kind == d_kind));
  end

  always_comb begin
    state_nxt = state_r;  gstg_nxt = gstg_r;
    set_nxt = set_r;      clr_nxt = clr_r;      clr_op_nxt = clr_op_r;
    p_nxt = p_r; q_nxt = q_r; j_nxt = j_r; k_nxt = k_r; hk_nxt = hk_r;
    tgt_nxt = tgt_r; ph_nxt = ph_r;
    sr_nxt = sr_r; sc_nxt = sc_r; vr_nxt = vr_r; vc_nxt = vc_r;
    pend_nxt = pend_r; idone_nxt = idone_r; doing_nxt = doing_r;
    ov_nxt = 1'b0;
    ofs_nxt = ofs_r; orow_nxt = orow_r; ocol_nxt = ocol_r;
    okind_nxt = okind_r; ostep_nxt = ostep_r;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    nk = qrts_pkg::kind_at(p_r, q_r, k_r + SW_'(1));

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ofs_nxt = qrts_pkg::FS_GIVEN;
          orow_nxt = '0; ocol_nxt = '0; okind_nxt = '0; ostep_nxt = '0;
          p_nxt = {{(CW_-4){1'b0}}, in_tile_row};
          q_nxt = {{(CW_-4){1'b0}}, in_tile_col};
          case (in_opcode)
            qrts_pkg::OP_RESTART: begin
              clr_nxt = '0; clr_op_nxt = 1'b1; state_nxt = S_CLEAR;
            end
            qrts_pkg::OP_FETCH: begin
              sr_nxt = grid.rows - CW_'(1);
              sc_nxt = grid.cols - CW_'(1);
              pend_nxt = 1'b0; idone_nxt = 1'b0; doing_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            qrts_pkg::OP_COMPLETE: begin
              if (p_nxt < grid.rows && q_nxt < grid.cols) state_nxt = S_HRD;
              else ov_nxt = 1'b1;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_CLEAR: begin
        we = 1'b1; wa = clr_r;
        if (clr_r == '0) wd = '{kind: qrts_pkg::K_QRS, status: qrts_pkg::ST_READY,
                                step: 4'd0};
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
          ov_nxt = clr_op_r;
        end
      end
      S_SCAN: begin
        ra = mk_addr(sr_r, sc_r);
        vr_nxt = sr_r; vc_nxt = sc_r;
        pend_nxt = !idone_r;
        if (!idone_r) begin
          if (sc_r == '0) begin
            if (sr_r == '0) idone_nxt = 1'b1;
            else begin
              sr_nxt = sr_r - CW_'(1);
              sc_nxt = grid.cols - CW_'(1);
            end
          end else sc_nxt = sc_r - CW_'(1);
        end
        if (pend_r && rd.status == qrts_pkg::ST_READY) begin
          we = 1'b1; wa = mk_addr(vr_r, vc_r);
          wd = rd; wd.status = qrts_pkg::ST_DOING;
          orow_nxt = vr_r[3:0]; ocol_nxt = vc_r[3:0];
          okind_nxt = rd.kind; ostep_nxt = rd.step;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (pend_r && rd.status == qrts_pkg::ST_DOING) begin
          doing_nxt = 1'b1;
        end else if (!pend_r && idone_r) begin
          ofs_nxt = doing_r ? qrts_pkg::FS_PENDING : qrts_pkg::FS_ALLDONE;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_HRD: begin
        ra = mk_addr(p_r, q_r);
        state_nxt = S_HEV;
      end
      S_HEV: begin
        we = 1'b1; wa = mk_addr(p_r, q_r);
        wd = rd; wd.status = qrts_pkg::ST_DONE;
        k_nxt = {1'b0, rd.step};
        hk_nxt = qrts_pkg::kind_at(p_r, q_r, {1'b0, rd.step});
        j_nxt = {{(CW_-4){1'b0}}, rd.step} + CW_'(1);
        case (hk_nxt)
          {1'b0, qrts_pkg::K_QRS}, {1'b0, qrts_pkg::K_QRD}: gstg_nxt = G_LOOP;
          {1'b0, qrts_pkg::K_SAPP}: gstg_nxt = G_TAIL;
          {1'b0, qrts_pkg::K_DAPP}: gstg_nxt = G_SELF;
          default: gstg_nxt = G_END;
        endcase
        state_nxt = S_GEN;
      end
      S_GEN: begin
        ph_nxt = 2'd0;
        tgt_nxt.step = k_r;
        case (gstg_r)
          G_LOOP: begin
            if (j_r < grid.cols) begin
              tgt_nxt.row = p_r; tgt_nxt.col = j_r;
              tgt_nxt.kind = (hk_r[1:0] == qrts_pkg::K_QRS) ? qrts_pkg::K_SAPP
                                                            : qrts_pkg::K_DAPP;
              j_nxt = j_r + CW_'(1);
              state_nxt = S_CRD;
            end else gstg_nxt = G_TAIL;
          end
          G_SELF: begin
            gstg_nxt = G_TAIL;
            if (nk != qrts_pkg::KX_NONE) begin
              tgt_nxt.row = p_r; tgt_nxt.col = q_r;
              tgt_nxt.kind = nk[1:0]; tgt_nxt.step = k_r + SW_'(1);
              state_nxt = S_CRD;
            end
          end
          G_TAIL: begin
            gstg_nxt = G_END;
            if (p_r + CW_'(1) < grid.rows) begin
              tgt_nxt.row = p_r + CW_'(1); tgt_nxt.col = q_r;
              tgt_nxt.kind = (hk_r[1:0] == qrts_pkg::K_QRS ||
                              hk_r[1:0] == qrts_pkg::K_QRD) ? qrts_pkg::K_QRD
                                                            : qrts_pkg::K_DAPP;
              state_nxt = S_CRD;
            end
          end
          default: begin
            ov_nxt = 1'b1; state_nxt = S_IDLE;
          end
        endcase
      end
      S_CRD: begin
        ra = mk_addr(d_r, d_c);
        if (d_final) set_nxt = 1'b1;
        else state_nxt = S_CEV;
        if (set_r) begin
          we = 1'b1; wa = mk_addr(tgt_r.row, tgt_r.col);
          wd = '{kind: tgt_r.kind, status: qrts_pkg::ST_READY, step: tgt_r.step[3:0]};
          set_nxt = 1'b0; state_nxt = S_GEN;
        end
      end
      S_CEV: begin
        if (!d_ok) state_nxt = S_GEN;
        else if (d_last) begin
          set_nxt = 1'b1; state_nxt = S_CRD;
        end else begin
          ph_nxt = ph_r + 2'd1; state_nxt = S_CRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      clr_op_r <= 1'b0;
      set_r    <= 1'b0;
      ov_r     <= 1'b0;
      gstg_r   <= G_END;
      pend_r   <= 1'b0;
      idone_r  <= 1'b0;
      doing_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      clr_op_r <= clr_op_nxt;
      set_r    <= set_nxt;
      ov_r     <= ov_nxt;
      gstg_r   <= gstg_nxt;
      pend_r   <= pend_nxt;
      idone_r  <= idone_nxt;
      doing_r  <= doing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; q_r <= q_nxt; j_r <= j_nxt; k_r <= k_nxt; hk_r <= hk_nxt;
    tgt_r <= tgt_nxt; ph_r <= ph_nxt;
    sr_r <= sr_nxt; sc_r <= sc_nxt; vr_r <= vr_nxt; vc_r <= vc_nxt;
    ofs_r <= ofs_nxt; orow_r <= orow_nxt; ocol_r <= ocol_nxt;
    okind_r <= okind_nxt; ostep_r <= ostep_nxt;
  end

endmodule

/* test/tiled_qr_task_scheduler_test.sv */
module tiled_qr_task_scheduler_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] status;
    logic [3:0] row;
    logic [3:0] col;
    logic [1:0] kind;
    logic [3:0] step;
  } sched_reply_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_opcode;
  logic [3:0] in_tile_row;
  logic [3:0] in_tile_col;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  logic       out_valid;
  logic [1:0] out_fetch_status;
  logic [3:0] out_task_row;
  logic [3:0] out_task_col;
  logic [1:0] out_task_kind;
  logic [3:0] out_task_step;

  tiled_qr_task_scheduler u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_tile_row      (in_tile_row),
    .in_tile_col      (in_tile_col),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_fetch_status (out_fetch_status),
    .out_task_row     (out_task_row),
    .out_task_col     (out_task_col),
    .out_task_kind    (out_task_kind),
    .out_task_step    (out_task_step)
  );

  // scheduler shadow state
  logic [1:0] tile_kind [16][16];
  logic [1:0] tile_stat [16][16];
  logic [3:0] tile_step [16][16];
  logic [4:0] rows_reg;
  logic [4:0] cols_reg;

  sched_reply_t replies_due[$];
  sched_reply_t last_reply;
  int           in_flight_row[$];
  int           in_flight_col[$];

  int beats_sent;
  int beats_checked;
  int mismatches;
  int fetch_given;
  int fetch_alldone;
  int burst_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int rows_used();
    if (rows_reg < 1) return 1;
    if (rows_reg > 16) return 16;
    return int'(rows_reg);
  endfunction

  function automatic int cols_used();
    if (cols_reg < 1) return 1;
    if (cols_reg > 16) return 16;
    return int'(cols_reg);
  endfunction

  function automatic bit on_grid(int r, int c);
    return r >= 0 && c >= 0 && r < rows_used() && c < cols_used();
  endfunction

  function automatic bit reached(int r, int c, int s);
    int st;
    if (!on_grid(r, c)) return s < 0;
    st = int'(tile_step[r][c]);
    if (st > s) return 1'b1;
    return st == s && tile_stat[r][c] == qrts_pkg::ST_DONE;
  endfunction

  function automatic bit reached_as(int r, int c, int s, logic [1:0] k);
    logic [1:0] kd;
    kd = on_grid(r, c) ? tile_kind[r][c] : qrts_pkg::K_QRS;
    return reached(r, c, s) && kd == k;
  endfunction

  function automatic bit update_done(int r, int c, int s);
    if (!on_grid(r, c)) return 1'b1;
    return reached_as(r, c, s, qrts_pkg::K_DAPP);
  endfunction

  function automatic logic [2:0] kind_for(int r, int c, int s);
    if (r == s) begin
      if (c == s) return {1'b0, qrts_pkg::K_QRS};
      if (c > s) return {1'b0, qrts_pkg::K_SAPP};
    end else if (r > s) begin
      if (c == s) return {1'b0, qrts_pkg::K_QRD};
      if (c > s) return {1'b0, qrts_pkg::K_DAPP};
    end
    return qrts_pkg::KX_NONE;
  endfunction

  function automatic bit sapp_free(int r, int c, int s);
    if (!on_grid(r, c)) return 1'b0;
    if (!on_grid(r - 1, c)) return 1'b1;
    return reached_as(s, s, s, qrts_pkg::K_QRS) && update_done(r, c, s - 1);
  endfunction

  function automatic bit qrd_free(int r, int c, int s);
    if (!on_grid(r, c)) return 1'b0;
    if (!reached(r - 1, c, s)) return 1'b0;
    return s == 0 || update_done(r, c, s - 1);
  endfunction

  function automatic bit dapp_free(int r, int c, int s);
    if (!on_grid(r, c)) return 1'b0;
    if (!reached_as(r, s, s, qrts_pkg::K_QRD)) return 1'b0;
    if (!reached(r - 1, c, s)) return 1'b0;
    return s == 0 || update_done(r, c, s - 1);
  endfunction

  function automatic void make_ready(int r, int c, logic [1:0] k, int s);
    if (!on_grid(r, c)) return;
    tile_kind[r][c] = k;
    tile_stat[r][c] = qrts_pkg::ST_READY;
    tile_step[r][c] = s[3:0];
  endfunction

  function automatic void clear_tiles();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) begin
        tile_kind[r][c] = qrts_pkg::K_QRS;
        tile_stat[r][c] = qrts_pkg::ST_NONE;
        tile_step[r][c] = '0;
      end
    tile_stat[0][0] = qrts_pkg::ST_READY;
  endfunction

  function automatic void retire_tile(int p, int q);
    int k;
    int n;
    logic [2:0] nk;
    if (!on_grid(p, q)) return;
    k = int'(tile_step[p][q]);
    n = cols_used();
    tile_stat[p][q] = qrts_pkg::ST_DONE;
    case (kind_for(p, q, k))
      {1'b0, qrts_pkg::K_QRS}: begin
        for (int j = k + 1; j < n; j++)
          if (sapp_free(p, j, k)) make_ready(p, j, qrts_pkg::K_SAPP, k);
        if (qrd_free(p + 1, q, k)) make_ready(p + 1, q, qrts_pkg::K_QRD, k);
      end
      {1'b0, qrts_pkg::K_SAPP}: begin
        if (dapp_free(p + 1, q, k)) make_ready(p + 1, q, qrts_pkg::K_DAPP, k);
      end
      {1'b0, qrts_pkg::K_QRD}: begin
        for (int j = k + 1; j < n; j++)
          if (dapp_free(p, j, k)) make_ready(p, j, qrts_pkg::K_DAPP, k);
        if (qrd_free(p + 1, q, k)) make_ready(p + 1, q, qrts_pkg::K_QRD, k);
      end
      {1'b0, qrts_pkg::K_DAPP}: begin
        nk = kind_for(p, q, k + 1);
        if (nk == {1'b0, qrts_pkg::K_QRS}) make_ready(p, q, qrts_pkg::K_QRS, k + 1);
        else if (nk == {1'b0, qrts_pkg::K_SAPP}) begin
          if (sapp_free(p, q, k + 1)) make_ready(p, q, qrts_pkg::K_SAPP, k + 1);
        end else if (nk == {1'b0, qrts_pkg::K_QRD}) begin
          if (qrd_free(p, q, k + 1)) make_ready(p, q, qrts_pkg::K_QRD, k + 1);
        end else if (nk == {1'b0, qrts_pkg::K_DAPP}) begin
          if (dapp_free(p, q, k + 1)) make_ready(p, q, qrts_pkg::K_DAPP, k + 1);
        end
        if (dapp_free(p + 1, q, k)) make_ready(p + 1, q, qrts_pkg::K_DAPP, k);
      end
      default: ;
    endcase
  endfunction

  function automatic sched_reply_t schedule_op(logic [1:0] op, int r, int c);
    sched_reply_t rep;
    rep = '{default: '0};
    if (op == qrts_pkg::OP_RESTART) clear_tiles();
    else if (op == qrts_pkg::OP_COMPLETE) retire_tile(r, c);
    else if (op == qrts_pkg::OP_FETCH) begin
      rep.status = qrts_pkg::FS_ALLDONE;
      for (int i = rows_used() - 1; i >= 0; i--)
        for (int j = cols_used() - 1; j >= 0; j--) begin
          if (tile_stat[i][j] == qrts_pkg::ST_READY) begin
            tile_stat[i][j] = qrts_pkg::ST_DOING;
            rep.status = qrts_pkg::FS_GIVEN;
            rep.row = i[3:0];
            rep.col = j[3:0];
            rep.kind = tile_kind[i][j];
            rep.step = tile_step[i][j];
            return rep;
          end
          if (tile_stat[i][j] == qrts_pkg::ST_DOING) rep.status = qrts_pkg::FS_PENDING;
        end
    end
    return rep;
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [3:0] r, logic [3:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 15));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_tile_row <= r;
    in_tile_col <= c;
    do @(posedge clk); while (busy);
    last_reply = schedule_op(op, int'(r), int'(c));
    replies_due.push_back(last_reply);
    beats_sent++;
    burst_left--;
    if (op == qrts_pkg::OP_FETCH && last_reply.status == qrts_pkg::FS_GIVEN) begin
      fetch_given++;
      in_flight_row.push_back(int'(last_reply.row));
      in_flight_col.push_back(int'(last_reply.col));
    end
    if (op == qrts_pkg::OP_FETCH && last_reply.status == qrts_pkg::FS_ALLDONE)
      fetch_alldone++;
    if (op == qrts_pkg::OP_RESTART) begin
      in_flight_row.delete();
      in_flight_col.delete();
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (replies_due.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == {1'b0, qrts_pkg::CFG_ROWS}) rows_reg = val;
    else if (idx == {1'b0, qrts_pkg::CFG_COLS}) cols_reg = val;
  endtask

  task automatic set_grid(logic [4:0] nr, logic [4:0] nc);
    wait_idle();
    write_reg({1'b0, qrts_pkg::CFG_ROWS}, nr);
    write_reg({1'b0, qrts_pkg::CFG_COLS}, nc);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    sched_reply_t want;
    if (rst_n && out_valid) begin
      beats_checked++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", out_fetch_status);
      end else begin
        want = replies_due.pop_front();
        if (out_fetch_status !== want.status || out_task_row !== want.row ||
            out_task_col !== want.col || out_task_kind !== want.kind ||
            out_task_step !== want.step) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want st%0d (%0d,%0d) k%0d s%0d, got st%0d (%0d,%0d) k%0d s%0d",
                     want.status, want.row, want.col, want.kind, want.step,
                     out_fetch_status, out_task_row, out_task_col, out_task_kind,
                     out_task_step);
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(2'd3, 4'hf, 4'hf);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'hf, 4'hf);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'd1, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'd0, 4'd1);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_RESTART, 4'hf, 4'hf);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    set_grid(5'd0, 5'd31);
    send_cmd(qrts_pkg::OP_RESTART, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'd5, 4'd5);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    set_grid(5'd1, 5'd1);
    send_cmd(qrts_pkg::OP_RESTART, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_FETCH, 4'd0, 4'd0);
    send_cmd(qrts_pkg::OP_COMPLETE, 4'd0, 4'd1);
  endtask

  // worker-pool style traffic: fetch tasks and retire them out of order, with stray completes, bad opcodes and restarts
  task automatic test_factorise(logic [4:0] nr, logic [4:0] nc, int beats);
    int pick;
    int k;
    set_grid(nr, nc);
    send_cmd(qrts_pkg::OP_RESTART, 4'd0, 4'd0);
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) send_cmd(qrts_pkg::OP_COMPLETE, 4'($urandom), 4'($urandom));
      else if (pick < 5) send_cmd(2'd3, 4'($urandom), 4'($urandom));
      else if (pick < 6) send_cmd(qrts_pkg::OP_RESTART, 4'($urandom), 4'($urandom));
      else if (last_reply.status == qrts_pkg::FS_ALLDONE && $urandom_range(0, 1))
        send_cmd(qrts_pkg::OP_RESTART, 4'd0, 4'd0);
      else if (in_flight_row.size() != 0 &&
               (pick < 50 || last_reply.status == qrts_pkg::FS_PENDING)) begin
        k = $urandom_range(0, in_flight_row.size() - 1);
        send_cmd(qrts_pkg::OP_COMPLETE, 4'(in_flight_row[k]), 4'(in_flight_col[k]));
        in_flight_row.delete(k);
        in_flight_col.delete(k);
      end else send_cmd(qrts_pkg::OP_FETCH, 4'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = '0;
    in_tile_row = '0;
    in_tile_col = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    beats_sent = 0;
    beats_checked = 0;
    mismatches = 0;
    fetch_given = 0;
    fetch_alldone = 0;
    burst_left = 0;
    rows_reg = 5'd16;
    cols_reg = 5'd16;
    last_reply = '{default: '0};
    clear_tiles();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_factorise(5'd16, 5'd16, 300);
    test_factorise(5'd1, 5'd16, 60);
    test_factorise(5'd16, 5'd1, 60);
    test_factorise(5'd31, 5'd0, 40);
    while (beats_sent < 1750)
      test_factorise(5'($urandom_range(1, 6)), 5'($urandom_range(1, 6)),
                     $urandom_range(40, 120));
    test_factorise(5'($urandom_range(17, 31)), 5'($urandom_range(1, 4)), 60);

    wait_idle();
    $display("%0d commands sent, %0d result beats checked", beats_sent, beats_checked);
    $display("%0d tasks handed out, %0d all-done replies", fetch_given, fetch_alldone);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/qrts_pkg.sv
hw/rtl/qrts_tile_mem.sv
hw/rtl/qrts_cfg.sv
hw/rtl/tiled_qr_task_scheduler.sv
test/tiled_qr_task_scheduler_test.sv
